@@ rtl/core/spectrum_bin_packetizer_macros.svh @@
// assertion macros used by the checker of this block
`ifndef SPECTRUM_BIN_PACKETIZER_MACROS_SVH
`define SPECTRUM_BIN_PACKETIZER_MACROS_SVH

// clocked assertion, ignored while reset is high
`define SPB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked assertion that is also checked across reset
`define SPB_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/core/spb_pkg.sv @@
package spb_pkg;

   // input item: one spectrum bin with its frame context
   typedef struct packed {
      logic [15:0] bin_value;
      logic [15:0] frame_bins;
      logic [31:0] frame_index;
   } req_payload_type;

   // result item: one halfword of a packet
   typedef struct packed {
      logic [15:0] halfword;
      logic        packet_end;
   } rsp_payload_type;

   // register reset and packet sizing
   localparam logic [13:0] MTU_RESET       = 14'd1500;
   localparam logic [13:0] MTU_SMALL_LIMIT = 14'd70;
   localparam logic [13:0] MTU_OVERHEAD    = 14'd68;
   localparam logic [15:0] HDR_WORD_BASE   = 16'd10;

   // fixed header and subheader contents
   localparam logic [15:0] HDR_TYPE        = 16'h3000;
   localparam logic [15:0] STREAM_ID_HI    = 16'h4000;
   localparam logic [15:0] STREAM_ID_LO    = 16'h0000;
   localparam logic [15:0] OUI_HI          = 16'h0000;
   localparam logic [15:0] OUI_LO          = 16'h1C2D;
   localparam logic [15:0] CLASS_HI        = 16'h534C;
   localparam logic [15:0] CLASS_LO        = 16'h8003;
   localparam logic [15:0] SUBHDR_FORMAT   = 16'd2;

   // halfword positions within a packet opening
   localparam logic [4:0] IDX_HDR_TYPE     = 5'd0;
   localparam logic [4:0] IDX_SIZE         = 5'd1;
   localparam logic [4:0] IDX_SID_HI       = 5'd2;
   localparam logic [4:0] IDX_SID_LO       = 5'd3;
   localparam logic [4:0] IDX_OUI_HI       = 5'd4;
   localparam logic [4:0] IDX_OUI_LO       = 5'd5;
   localparam logic [4:0] IDX_CLASS_HI     = 5'd6;
   localparam logic [4:0] IDX_CLASS_LO     = 5'd7;
   localparam logic [4:0] IDX_FIRST_BIN    = 5'd14;
   localparam logic [4:0] IDX_BIN_COUNT    = 5'd15;
   localparam logic [4:0] IDX_FORMAT       = 5'd16;
   localparam logic [4:0] IDX_FRAME_BINS   = 5'd17;
   localparam logic [4:0] IDX_FRAME_HI     = 5'd18;
   localparam logic [4:0] IDX_FRAME_LO     = 5'd19;
   localparam logic [4:0] IDX_BIN          = 5'd20;

endpackage

@@ rtl/core/spectrum_bin_packetizer.sv @@
// an input transfer reaches rsp via the work register, then the output register
// a bin that opens a packet gives 21 results (header, subheader, bin)
// and holds req_stall high while its header and subheader go out
// other bins give 1 result; between openings, unstalled, one transfer per cycle per side
// the single output register sets the pace: one halfword leaves per cycle unless rsp_stall
// synchronous reset: packet state and sequence clear, bins per packet reset for MTU 1500
module spectrum_bin_packetizer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  spb_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output spb_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [13:0]              csr_data
);
   import spb_pkg::*;

   // bins per packet, kept ready from the last register write
   logic [12:0] bpp_ff, bpp_in;

   // packet and frame tracking state
   logic [3:0]  seq_ff, seq_in;
   logic [15:0] fpos_ff, fpos_in;
   logic [15:0] ppos_ff, ppos_in;
   logic [15:0] pcount_ff, pcount_in;

   // work register: the accepted bin and what its packet opening needs
   logic        stg_valid_ff, stg_valid_in;
   logic [4:0]  stg_idx_ff, stg_idx_in;
   logic        stg_start_ff;
   logic        stg_last_ff;
   logic [3:0]  stg_seq_ff;
   logic [15:0] stg_words_ff;
   logic [15:0] stg_fpos_ff;
   logic [15:0] stg_count_ff;
   logic [15:0] stg_fbins_ff;
   logic [31:0] stg_findex_ff;
   logic [15:0] stg_bin_ff;

   // output register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   // packet decisions for the bin at the input
   logic        req_xfer;
   logic        start;
   logic [15:0] fbins;
   logic [15:0] fpos0;
   logic [15:0] left;
   logic [15:0] count;
   logic [15:0] pkt_count;
   logic [15:0] ppos_next;
   logic [15:0] fpos_next;
   logic        last;

   // output side control
   logic        out_load;
   logic        final_word;
   logic [15:0] word;

   // configuration write: always ready
   assign csr_ready = 1'b1;

   always_comb begin
      if (csr_data < MTU_SMALL_LIMIT) begin
         bpp_in = 13'd1;
      end else begin
         bpp_in = 13'((csr_data - MTU_OVERHEAD) >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff <= 13'((MTU_RESET - MTU_OVERHEAD) >> 1);
      end else if (csr_valid && csr_ready) begin
         bpp_ff <= bpp_in;
      end
   end

   // packet sizing and state update for the incoming bin
   always_comb begin
      fbins     = (req_payload.frame_bins == 16'd0) ? 16'd1 : req_payload.frame_bins;
      start     = (ppos_ff == 16'd0);
      fpos0     = (start && (fpos_ff >= fbins)) ? 16'd0 : fpos_ff;
      left      = fbins - fpos0;
      count     = (left < {3'd0, bpp_ff}) ? left : {3'd0, bpp_ff};
      pkt_count = start ? count : pcount_ff;
      ppos_next = ppos_ff + 16'd1;
      fpos_next = fpos0 + 16'd1;
      last      = (ppos_next >= pkt_count);

      seq_in    = seq_ff;
      fpos_in   = fpos_ff;
      ppos_in   = ppos_ff;
      pcount_in = pcount_ff;
      if (req_xfer) begin
         pcount_in = pkt_count;
         if (last) begin
            ppos_in = 16'd0;
            seq_in  = seq_ff + 4'd1;
            fpos_in = (fpos_next >= fbins) ? 16'd0 : fpos_next;
         end else begin
            ppos_in = ppos_next;
            fpos_in = fpos_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff    <= '0;
         fpos_ff   <= '0;
         ppos_ff   <= '0;
         pcount_ff <= '0;
      end else begin
         seq_ff    <= seq_in;
         fpos_ff   <= fpos_in;
         ppos_ff   <= ppos_in;
         pcount_ff <= pcount_in;
      end
   end

   // handshake between work register and output register
   assign out_load   = stg_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign final_word = !stg_start_ff || (stg_idx_ff == IDX_BIN);
   assign req_stall  = stg_valid_ff && !(out_load && final_word);
   assign req_xfer   = req_valid && !req_stall;

   // work register control
   always_comb begin
      stg_valid_in = stg_valid_ff;
      stg_idx_in   = stg_idx_ff;
      if (req_xfer) begin
         stg_valid_in = 1'b1;
         stg_idx_in   = IDX_HDR_TYPE;
      end else if (out_load && final_word) begin
         stg_valid_in = 1'b0;
      end else if (out_load) begin
         stg_idx_in   = stg_idx_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         stg_idx_ff   <= '0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         stg_idx_ff   <= stg_idx_in;
      end
   end

   // work register payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         stg_start_ff  <= start;
         stg_last_ff   <= last;
         stg_seq_ff    <= seq_ff;
         stg_words_ff  <= HDR_WORD_BASE + {1'b0, count[15:1]};
         stg_fpos_ff   <= fpos0;
         stg_count_ff  <= count;
         stg_fbins_ff  <= fbins;
         stg_findex_ff <= req_payload.frame_index;
         stg_bin_ff    <= req_payload.bin_value;
      end
   end

   // halfword select for the current position
   always_comb begin
      if (!stg_start_ff) begin
         word = stg_bin_ff;
      end else begin
         case (stg_idx_ff)
            IDX_HDR_TYPE:   word = HDR_TYPE | {12'd0, stg_seq_ff};
            IDX_SIZE:       word = stg_words_ff;
            IDX_SID_HI:     word = STREAM_ID_HI;
            IDX_SID_LO:     word = STREAM_ID_LO;
            IDX_OUI_HI:     word = OUI_HI;
            IDX_OUI_LO:     word = OUI_LO;
            IDX_CLASS_HI:   word = CLASS_HI;
            IDX_CLASS_LO:   word = CLASS_LO;
            IDX_FIRST_BIN:  word = stg_fpos_ff;
            IDX_BIN_COUNT:  word = stg_count_ff;
            IDX_FORMAT:     word = SUBHDR_FORMAT;
            IDX_FRAME_BINS: word = stg_fbins_ff;
            IDX_FRAME_HI:   word = stg_findex_ff[31:16];
            IDX_FRAME_LO:   word = stg_findex_ff[15:0];
            IDX_BIN:        word = stg_bin_ff;
            default:        word = 16'd0;
         endcase
      end
   end

   // output register
   always_comb begin
      rsp_valid_in   = out_load || (rsp_valid_ff && rsp_stall);
      rsp_payload_in = rsp_payload_ff;
      if (out_load) begin
         rsp_payload_in.halfword   = word;
         rsp_payload_in.packet_end = final_word && stg_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

@@ rtl/core/spb_checker.sv @@
`include "spectrum_bin_packetizer_macros.svh"

module spb_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input spb_pkg::rsp_payload_type rsp_payload
);
   import spb_pkg::*;

   // result side events
   logic rsp_xfer;
   logic rsp_wait;
   logic end_xfer;
   logic hdr_word;

   assign rsp_xfer = rsp_valid && !rsp_stall;
   assign rsp_wait = rsp_valid && rsp_stall;
   assign end_xfer = rsp_xfer && rsp_payload.packet_end;
   assign hdr_word = (rsp_payload.halfword[15:4] == HDR_TYPE[15:4]);

   // a stalled result holds
   `SPB_ASSERT(a_rsp_hold, rsp_wait |=> (rsp_valid && $stable(rsp_payload)), "held result changed")

   // reset empties the output
   `SPB_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")

   // the transfer right after a packet end opens a new packet header
   `SPB_ASSERT(a_hdr_after_end, end_xfer ##1 rsp_xfer |-> hdr_word, "no header after packet end")

   // the input stalls only while a result is on its way out
   `SPB_ASSERT(a_stall_pending, req_stall |=> rsp_valid, "input stalled with no result pending")

endmodule

bind spectrum_bin_packetizer spb_checker u_spb_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
